/* src/sbgtc_pkg.sv */
package sbgtc_pkg;

  localparam logic [7:0] CH_DIGIT_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;  // '9'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;  // 'z'
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;  // 'Z'
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic [5:0] VAL_LOWER_BASE = 6'd10;
  localparam logic [5:0] VAL_UPPER_BASE = 6'd36;
  localparam logic [5:0] VAL_UNDERSCORE = 6'd62;
  localparam logic [5:0] VAL_DOLLAR = 6'd63;

  localparam logic [1:0] GROUP_FULL = 2'd3;

  typedef enum logic {
    JOB_DEC,
    JOB_ENC
  } job_kind_t;

  // One unit of work for the emitter: a whole encoded group or one decoded byte
  typedef struct packed {
    job_kind_t       kind;
    logic [1:0]      cnt;    // bytes in the group (encode)
    logic [5:0]      head;   // packed top bit pairs (encode)
    logic [2:0][7:0] bytes;  // group bytes, or decoded byte in entry 0
    logic            last;
    logic            bad;
  } job_t;

  function automatic logic [7:0] sym_of_value(input logic [5:0] v);
    logic [7:0] c;
    c = CH_DOLLAR;
    if (v < VAL_LOWER_BASE) begin
      c = CH_DIGIT_0 + {2'b00, v};
    end else if (v < VAL_UPPER_BASE) begin
      c = CH_LOWER_A + {2'b00, v - VAL_LOWER_BASE};
    end else if (v < VAL_UNDERSCORE) begin
      c = CH_UPPER_A + {2'b00, v - VAL_UPPER_BASE};
    end else if (v == VAL_UNDERSCORE) begin
      c = CH_UNDERSCORE;
    end
    return c;
  endfunction

  // Bit 6 flags a character outside the alphabet; bits 5:0 hold its value
  function automatic logic [6:0] value_of_sym(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h40;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0;
      r = {1'b0, d[5:0]};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A + {2'b00, VAL_LOWER_BASE};
      r = {1'b0, d[5:0]};
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A + {2'b00, VAL_UPPER_BASE};
      r = {1'b0, d[5:0]};
    end else if (c == CH_UNDERSCORE) begin
      r = {1'b0, VAL_UNDERSCORE};
    end else if (c == CH_DOLLAR) begin
      r = {1'b0, VAL_DOLLAR};
    end
    return r;
  endfunction

endpackage

/* src/sbgtc_in_if.sv */
interface sbgtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

/* src/sbgtc_out_if.sv */
interface sbgtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       bad_char;
  logic       stream_end;

  modport source (output valid, out_byte, run_last, bad_char, stream_end, input ready);
  modport sink (input valid, out_byte, run_last, bad_char, stream_end, output ready);
endinterface

/* src/sbgtc_front.sv */
module sbgtc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_ready,
  output logic              q_push,
  output sbgtc_pkg::job_t   q_job
);
  import sbgtc_pkg::*;

  logic            mode_r;
  logic [1:0]      group_pos_r, group_pos_nxt;
  logic [5:0]      head_bits_r, head_bits_nxt;
  logic [2:0][7:0] group_r;
  logic [2:0][7:0] gb;
  logic [1:0]      enc_pos;
  logic [1:0]      n;
  logic [6:0]      vs;
  logic [1:0]      pair;
  logic            has_job;
  logic            acc;
  job_t            job;

  assign in_ready = q_ready;
  assign acc      = in_valid && q_ready;
  assign q_push   = acc && has_job;
  assign q_job    = job;

  always_comb begin
    group_pos_nxt = group_pos_r;
    head_bits_nxt = head_bits_r;
    has_job       = 1'b0;
    job           = '0;
    enc_pos       = (group_pos_r == GROUP_FULL) ? 2'd0 : group_pos_r;
    gb            = group_r;
    gb[enc_pos]   = in_byte;
    n             = enc_pos + 2'd1;
    vs            = value_of_sym(in_byte);
    pair          = 2'b00;
    if (!mode_r) begin
      if (n != GROUP_FULL && !in_last) begin
        group_pos_nxt = n;
      end else begin
        has_job       = 1'b1;
        job.kind      = JOB_ENC;
        job.cnt       = n;
        job.head      = {gb[0][7:6],
                         (n >= 2'd2) ? gb[1][7:6] : 2'b00,
                         (n == GROUP_FULL) ? gb[2][7:6] : 2'b00};
        job.bytes     = gb;
        job.last      = in_last;
        group_pos_nxt = 2'd0;
      end
    end else begin
      job.kind = JOB_DEC;
      job.last = in_last;
      job.bad  = vs[6];
      if (group_pos_r == 2'd0) begin
        // head character: keep its value, speak only if it is bad
        head_bits_nxt = vs[6] ? 6'd0 : vs[5:0];
        group_pos_nxt = in_last ? 2'd0 : 2'd1;
        has_job       = vs[6];
      end else begin
        case (group_pos_r)
          2'd1:    pair = head_bits_r[5:4];
          2'd2:    pair = head_bits_r[3:2];
          2'd3:    pair = head_bits_r[1:0];
          default: pair = 2'b00;
        endcase
        has_job       = 1'b1;
        job.bytes[0]  = vs[6] ? 8'h00 : {pair, vs[5:0]};
        group_pos_nxt = (in_last || group_pos_r == GROUP_FULL) ? 2'd0
                                                               : group_pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      group_pos_r <= 2'd0;
      head_bits_r <= 6'd0;
    end else if (cfg_we) begin
      mode_r      <= cfg_data;
      group_pos_r <= 2'd0;
      head_bits_r <= 6'd0;
    end else if (acc) begin
      group_pos_r <= group_pos_nxt;
      head_bits_r <= head_bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !mode_r) begin
      group_r[enc_pos] <= in_byte;
    end
  end

endmodule

/* src/sbgtc_queue.sv */
module sbgtc_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sbgtc_pkg::job_t push_job,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output sbgtc_pkg::job_t pop_job
);
  import sbgtc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign pop_valid  = (count_r != '0);
  assign push_ready = (count_r != CW'(DEPTH)) || pop;
  assign pop_job    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> count_r != CW'(DEPTH)) else $error("push into full queue");
`endif

endmodule

/* src/sbgtc_back.sv */
module sbgtc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  sbgtc_pkg::job_t q_job,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            bad_char,
  output logic            stream_end
);
  import sbgtc_pkg::*;

  job_t       job_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic [1:0] last_idx;
  logic       fire, done, load, fin;
  logic [7:0] ch;

  assign last_idx  = (job_r.kind == JOB_ENC) ? job_r.cnt : 2'd0;
  assign out_valid = busy_r;
  assign fire      = busy_r && out_ready;
  assign done      = fire && (idx_r == last_idx);
  assign load      = q_valid && (!busy_r || done);
  assign q_pop     = load;
  assign fin       = (idx_r == job_r.cnt);

  always_comb begin
    case (idx_r)
      2'd0:    ch = sym_of_value(job_r.head);
      2'd1:    ch = sym_of_value(job_r.bytes[0][5:0]);
      2'd2:    ch = sym_of_value(job_r.bytes[1][5:0]);
      2'd3:    ch = sym_of_value(job_r.bytes[2][5:0]);
      default: ch = 8'h00;
    endcase
    if (job_r.kind == JOB_DEC) begin
      out_byte   = job_r.bytes[0];
      run_last   = 1'b1;
      bad_char   = job_r.bad;
      stream_end = job_r.last;
    end else begin
      out_byte   = ch;
      run_last   = fin;
      bad_char   = 1'b0;
      stream_end = fin && job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= last_idx) else $error("emit index past end of job");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !load) |=> !busy_r) else $error("emitter busy after last result");
  a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> busy_r && idx_r == 2'd0) else $error("job load did not restart index");
`endif

endmodule

/* src/six_bit_group_text_codec.sv */
// Six-bit group text codec: bytes to a 64-symbol alphabet (0-9 a-z A-Z _ $)
// and back, in groups of up to three bytes led by one head character.
// Channels: in_ch takes requests (in_byte, in_last); out_ch gives results
// (out_byte, run_last, bad_char, stream_end). Both use valid/ready, and a
// request or result moves at a rising edge with valid and ready high.
// cfg_we/cfg_data write decode_mode; the user must do so while the block is
// idle; the block does not enforce this. The write restarts group framing.
// Path: the job built from a request is queued at the edge that takes it,
// then loaded into the emitter register once the emitter is free or is
// finishing its last result; its first result is then valid on out_ch.
// Throughput: one request per cycle is taken while the job queue has room;
// the emitter gives one result per cycle while out_ch is ready, so encoding
// gives four results per full group of three bytes and decoding one result
// per data character. The emitter's single output register sets that rate.
// Reset (synchronous, rst_n low) selects encode mode, empties the queue and
// clears framing. When the receiver stalls, the result holds on out_ch,
// the queue fills and in_ch ready drops only once it is full.
module six_bit_group_text_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  sbgtc_in_if.sink    in_ch,
  sbgtc_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_data
);
  import sbgtc_pkg::*;

  // Classifier to queue
  logic q_ready;
  logic q_push;
  job_t push_job;

  // Queue to emitter
  logic q_valid;
  logic q_pop;
  job_t pop_job;

  // Front: gather encode groups, track decode framing, build jobs
  sbgtc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .in_last  (in_ch.in_last),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // Short job queue: lets the front keep taking requests while results wait
  sbgtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (pop_job)
  );

  // Back: hold one job, emit its results one per cycle when out_ch is ready
  sbgtc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .run_last   (out_ch.run_last),
    .bad_char   (out_ch.bad_char),
    .stream_end (out_ch.stream_end)
  );

endmodule
